// ----- hdl/i2cmes_pkg.sv -----
`timescale 1ns / 1ps

package i2cmes_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_EVENT = 2'd2,
    MODE_ERROR = 2'd3
  } mode_t;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_AF   = 3'd1;
  localparam logic [2:0] ERR_ARLO = 3'd2;
  localparam logic [2:0] ERR_BERR = 3'd3;
  localparam logic [2:0] ERR_OVR  = 3'd4;

  localparam logic [15:0] SR1_SB      = 16'h0001;
  localparam logic [15:0] SR1_ADDR    = 16'h0002;
  localparam logic [15:0] SR1_BTF_TXE = 16'h0084;
  localparam logic [15:0] SR1_TXE     = 16'h0080;
  localparam logic [15:0] SR1_RXNE    = 16'h0040;
  localparam logic [15:0] SR1_AF      = 16'h0400;
  localparam logic [15:0] SR1_ARLO    = 16'h0200;
  localparam logic [15:0] SR1_BERR    = 16'h0100;
  localparam logic [15:0] SR1_OVR     = 16'h0800;
  localparam logic [15:0] SR2_MSL     = 16'h0001;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  load_index;
    logic [7:0]  load_byte;
    logic [7:0]  slave_address;
    logic        read_not_write;
    logic [7:0]  byte_count;
    logic [15:0] status_one;
    logic [15:0] status_two;
    logic [7:0]  received_data;
  } in_t;

  typedef struct packed {
    logic       start_request;
    logic       data_write;
    logic [7:0] data_value;
    logic       stop_request;
    logic       ack_disable;
    logic       buffer_irq_off;
    logic       event_irq_off;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic [2:0] error_cleared;
    logic [7:0] bytes_left;
  } out_t;

  typedef struct packed {
    logic       direction_rx;
    logic [7:0] target_address;
    logic [7:0] remaining;
    logic [7:0] tx_position;
    logic [7:0] rx_position;
  } seq_state_t;

  // buffer read request raised by a decoded item
  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_pos;
  } buf_req_t;

endpackage

// ----- hdl/i2cmes_ram.sv -----
`timescale 1ns / 1ps

module i2cmes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/i2cmes_decode.sv -----
`timescale 1ns / 1ps

module i2cmes_decode (
  input  i2cmes_pkg::in_t        item,
  input  i2cmes_pkg::seq_state_t state,
  output i2cmes_pkg::seq_state_t state_next,
  output i2cmes_pkg::out_t       result,
  output i2cmes_pkg::buf_req_t   req
);

  logic [7:0] rem_dec;
  logic [15:0] sr1;
  logic msl;

  assign sr1     = item.status_one;
  assign msl     = (item.status_two & i2cmes_pkg::SR2_MSL) != 16'h0000;
  assign rem_dec = (state.remaining != 8'd0) ? state.remaining - 8'd1 : state.remaining;

  always_comb begin
    state_next = state;
    result     = '0;
    req        = '0;
    unique case (item.mode)
      i2cmes_pkg::MODE_LOAD: begin
      end
      i2cmes_pkg::MODE_START: begin
        state_next.direction_rx   = item.read_not_write;
        state_next.target_address = {item.slave_address[7:1], item.read_not_write};
        state_next.remaining      = item.byte_count;
        result.start_request      = 1'b1;
      end
      i2cmes_pkg::MODE_EVENT: begin
        priority if ((sr1 & i2cmes_pkg::SR1_SB) != 16'h0000) begin
          result.data_write = 1'b1;
          result.data_value = state.target_address;
        end else if (!msl) begin
        end else if ((sr1 & i2cmes_pkg::SR1_ADDR) != 16'h0000) begin
          if (!state.direction_rx) begin
            // first byte always comes from slot 0
            result.data_write      = 1'b1;
            req.rd_en              = 1'b1;
            req.rd_pos             = 8'd0;
            state_next.tx_position = 8'd1;
            state_next.remaining   = rem_dec;
            result.buffer_irq_off  = (rem_dec == 8'd0);
          end else begin
            state_next.rx_position = 8'd0;
            result.ack_disable     = (state.remaining == 8'd1);
            result.stop_request    = (state.remaining == 8'd1);
          end
        end else if ((sr1 & i2cmes_pkg::SR1_BTF_TXE) == i2cmes_pkg::SR1_TXE) begin
          if (state.remaining != 8'd0) begin
            result.data_write      = 1'b1;
            req.rd_en              = 1'b1;
            req.rd_pos             = state.tx_position;
            state_next.tx_position = state.tx_position + 8'd1;
            state_next.remaining   = rem_dec;
            result.buffer_irq_off  = (rem_dec == 8'd0);
          end
        end else if ((sr1 & i2cmes_pkg::SR1_BTF_TXE) == i2cmes_pkg::SR1_BTF_TXE) begin
          result.stop_request  = 1'b1;
          result.event_irq_off = 1'b1;
        end else if ((sr1 & i2cmes_pkg::SR1_RXNE) != 16'h0000) begin
          result.rx_valid        = 1'b1;
          result.rx_index        = state.rx_position;
          result.rx_byte         = item.received_data;
          state_next.rx_position = state.rx_position + 8'd1;
          state_next.remaining   = rem_dec;
          result.ack_disable     = (rem_dec == 8'd1);
          result.stop_request    = (rem_dec == 8'd1);
        end else begin
        end
      end
      i2cmes_pkg::MODE_ERROR: begin
        priority if ((sr1 & i2cmes_pkg::SR1_AF) != 16'h0000) begin
          result.error_cleared = i2cmes_pkg::ERR_AF;
        end else if ((sr1 & i2cmes_pkg::SR1_ARLO) != 16'h0000) begin
          result.error_cleared = i2cmes_pkg::ERR_ARLO;
        end else if ((sr1 & i2cmes_pkg::SR1_BERR) != 16'h0000) begin
          result.error_cleared = i2cmes_pkg::ERR_BERR;
        end else if ((sr1 & i2cmes_pkg::SR1_OVR) != 16'h0000) begin
          result.error_cleared = i2cmes_pkg::ERR_OVR;
        end else begin
          result.error_cleared = i2cmes_pkg::ERR_NONE;
        end
      end
      default: begin
      end
    endcase
    result.bytes_left = state_next.remaining;
  end

endmodule

// ----- hdl/i2c_master_event_sequencer_top.sv -----
`timescale 1ns / 1ps

// channel   | valid      | stall      | payload
// ----------+------------+------------+------------------------------
// input     | in_valid   | in_stall   | in_data  (i2cmes_pkg::in_t)
// output    | out_valid  | out_stall  | out_data (i2cmes_pkg::out_t)
//
// One item per cycle while the output is not stalled; after its transfer in, a result
// passes the registered transmit buffer read stage, then the output register.
// Sequencer state updates at the input transfer, so the next item sees it at once.
// Reset clears the sequencer state; the transmit buffer RAM is not cleared.
// A stalled output holds its result; input stalls only when the read stage
// and the output register are both full.

module i2c_master_event_sequencer_top #(
  parameter int BUF_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cmes_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cmes_pkg::out_t out_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  i2cmes_pkg::seq_state_t state;
  i2cmes_pkg::seq_state_t state_next;
  i2cmes_pkg::out_t       dec_result;
  i2cmes_pkg::buf_req_t   dec_req;

  logic             accept;
  logic             advance;
  logic             s1_valid;
  i2cmes_pkg::out_t s1_res;
  i2cmes_pkg::out_t s1_merged;
  logic             s1_ram_sel;
  logic             s1_in_range;
  logic [7:0]       ram_q;
  logic             wr_en;
  logic [8:0]       load_ext;
  logic [8:0]       rd_ext;
  logic             rd_in_range;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  i2cmes_decode u_decode (
    .item       (in_data),
    .state      (state),
    .state_next (state_next),
    .result     (dec_result),
    .req        (dec_req)
  );

  assign load_ext    = {4'd0, in_data.load_index};
  assign rd_ext      = {1'b0, dec_req.rd_pos};
  assign rd_in_range = rd_ext < 9'(BUF_DEPTH);
  assign wr_en       = accept && (in_data.mode == i2cmes_pkg::MODE_LOAD) &&
                       (load_ext < 9'(BUF_DEPTH));

  i2cmes_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tx_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_ext[AW-1:0]),
    .wr_data (in_data.load_byte),
    .rd_en   (accept && dec_req.rd_en),
    .rd_addr (rd_ext[AW-1:0]),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res      <= dec_result;
      s1_ram_sel  <= dec_req.rd_en;
      s1_in_range <= rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // merge the buffer byte into the result; slots past the end send zero
  always_comb begin
    s1_merged = s1_res;
    if (s1_ram_sel) begin
      s1_merged.data_value = s1_in_range ? ram_q : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= s1_merged;
    end
  end

`ifndef SYNTH
  a_ram_sel_writes: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ram_sel |-> s1_res.data_write)
    else $error("buffer read without data register write");

  a_count_no_rise: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.mode != i2cmes_pkg::MODE_START)
      |=> state.remaining <= $past(state.remaining))
    else $error("remaining count rose outside a start");

  a_rx_tx_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.rx_valid && out_data.data_write))
    else $error("receive delivery and data write in one result");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.error_cleared != i2cmes_pkg::ERR_NONE)
      |-> !out_data.data_write && !out_data.start_request && !out_data.rx_valid)
    else $error("error result carries other requests");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with free pipeline slot");
`endif

endmodule
